### hdl/pn3d_pkg.sv
// ----------------------------------------------------------------------------
// Perlin noise 3D package
// Shared types, constants and the gradient function of the noise datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pn3d_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int CELL_W      = 8;
  localparam int TABLE_DEPTH = 1 << CELL_W;
  localparam int COORD_W     = 32;
  localparam int OUT_W       = 20;
  localparam int CFG_W       = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int GRAD_W      = 20;
  localparam int LERP_W      = 24;
  localparam int PROD_W      = 42;
  localparam int FADE_W      = 18;
  localparam int SUM_W       = 25;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = 2;
  localparam int Q_CNT_W     = 3;
  localparam int IN_DATA_W   = 112;
  localparam int OUT_DATA_W  = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_HIGH = 2'd2;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef logic [CELL_W-1:0]    hash_t;

  typedef struct packed {
    frac_t [2:0] frac;
    hash_t [7:0] hash;
  } item_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] offset;
    logic signed [CFG_W-1:0] low;
    logic signed [CFG_W-1:0] high;
  } cfg_t;

  function automatic logic signed [GRAD_W-1:0] grad(input hash_t hash,
                                                    input logic signed [17:0] x,
                                                    input logic signed [17:0] y,
                                                    input logic signed [17:0] z);
    logic [3:0] h;
    logic signed [GRAD_W-1:0] u;
    logic signed [GRAD_W-1:0] v;
    logic signed [GRAD_W-1:0] su;
    logic signed [GRAD_W-1:0] sv;
    h  = hash[3:0];
    u  = (h < 4'd8) ? GRAD_W'(x) : GRAD_W'(y);
    v  = (h < 4'd4) ? GRAD_W'(y) :
         ((h == 4'd12 || h == 4'd14) ? GRAD_W'(x) : GRAD_W'(z));
    su = h[0] ? -u : u;
    sv = h[1] ? -v : v;
    return su + sv;
  endfunction

endpackage

`default_nettype wire

### hdl/pn3d_front.sv
// ----------------------------------------------------------------------------
// Perlin noise 3D front end
// Accepts items, loads the permutation table copies and hashes the corners.
// ----------------------------------------------------------------------------
`default_nettype none

module pn3d_front
  import pn3d_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 in_mode_i,
  input  wire logic [CELL_W-1:0]    in_index_i,
  input  wire logic [CELL_W-1:0]    in_value_i,
  input  wire logic [COORD_W-1:0]   in_x_i,
  input  wire logic [COORD_W-1:0]   in_y_i,
  input  wire logic [COORD_W-1:0]   in_z_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output item_t                     out_item_o
);

  logic en;

  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic s1_load_q, s2_load_q, s3_load_q, s4_load_q;
  hash_t s1_idx_q, s2_idx_q, s3_idx_q;
  hash_t s1_val_q, s2_val_q, s3_val_q;
  hash_t s1_xc_q, s1_yc_q, s1_zc_q, s2_yc_q, s2_zc_q, s3_zc_q;
  frac_t [2:0] s1_f_q, s2_f_q, s3_f_q, s4_f_q;

  hash_t m1 [TABLE_DEPTH];
  hash_t m2 [2][TABLE_DEPTH];
  hash_t m3 [4][TABLE_DEPTH];

  hash_t       x0_q, x1_q;
  hash_t [1:0][1:0] t2_q;
  hash_t [7:0] h_q;

  hash_t       xc1;
  hash_t [1:0] base2;
  hash_t [3:0] base3;

  assign en          = !(s4_v_q && !s4_load_q) || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = s4_v_q && !s4_load_q;
  assign out_item_o  = '{frac: s4_f_q, hash: h_q};

  assign xc1      = s1_xc_q + 8'd1;
  assign base2[0] = x0_q + s2_yc_q;
  assign base2[1] = x1_q + s2_yc_q;
  assign base3[0] = t2_q[0][0] + s3_zc_q;
  assign base3[1] = t2_q[1][0] + s3_zc_q;
  assign base3[2] = t2_q[0][1] + s3_zc_q;
  assign base3[3] = t2_q[1][1] + s3_zc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_load_q <= (in_mode_i == MODE_LOAD);
      s1_idx_q  <= in_index_i;
      s1_val_q  <= in_value_i;
      s1_xc_q   <= in_x_i[FRAC_BITS +: CELL_W];
      s1_yc_q   <= in_y_i[FRAC_BITS +: CELL_W];
      s1_zc_q   <= in_z_i[FRAC_BITS +: CELL_W];
      s1_f_q    <= {in_z_i[FRAC_BITS-1:0], in_y_i[FRAC_BITS-1:0], in_x_i[FRAC_BITS-1:0]};
      s2_load_q <= s1_load_q;
      s2_idx_q  <= s1_idx_q;
      s2_val_q  <= s1_val_q;
      s2_yc_q   <= s1_yc_q;
      s2_zc_q   <= s1_zc_q;
      s2_f_q    <= s1_f_q;
      s3_load_q <= s2_load_q;
      s3_idx_q  <= s2_idx_q;
      s3_val_q  <= s2_val_q;
      s3_zc_q   <= s2_zc_q;
      s3_f_q    <= s2_f_q;
      s4_load_q <= s3_load_q;
      s4_f_q    <= s3_f_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s1_v_q) begin
      if (s1_load_q) begin
        m1[s1_idx_q] <= s1_val_q;
      end else begin
        x0_q <= m1[s1_xc_q];
        x1_q <= m1[xc1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 2; k++) begin
      if (en && s2_v_q) begin
        if (s2_load_q) begin
          m2[k][s2_idx_q] <= s2_val_q;
        end else begin
          t2_q[k][0] <= m2[k][base2[k]];
          t2_q[k][1] <= m2[k][hash_t'(base2[k] + 8'd1)];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      if (en && s3_v_q) begin
        if (s3_load_q) begin
          m3[k][s3_idx_q] <= s3_val_q;
        end else begin
          h_q[k]   <= m3[k][base3[k]];
          h_q[k+4] <= m3[k][hash_t'(base3[k] + 8'd1)];
        end
      end
    end
  end

endmodule

`default_nettype wire

### hdl/pn3d_queue.sv
// ----------------------------------------------------------------------------
// Perlin noise 3D queue
// Small first-in first-out buffer between the hashing and the blending part.
// ----------------------------------------------------------------------------
`default_nettype none

module pn3d_queue
  import pn3d_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire item_t              in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output item_t                   out_item_o,
  output logic [Q_CNT_W-1:0]      count_o
);

  item_t                mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_q, rd_q;
  logic [Q_CNT_W-1:0]   cnt_q;
  logic                 push, pop;

  assign in_ready_o  = (cnt_q != Q_CNT_W'(Q_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_q];
  assign count_o     = cnt_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_item_i;
  end

endmodule

`default_nettype wire

### hdl/pn3d_back.sv
// ----------------------------------------------------------------------------
// Perlin noise 3D back end
// Fade curves, gradients, trilinear blending, offset and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module pn3d_back
  import pn3d_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire item_t              in_item_i,
  input  wire cfg_t               cfg_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [OUT_W-1:0]        out_data_o
);

  localparam logic signed [21:0] FADE_A = 22'sd15 <<< FRAC_BITS;
  localparam logic signed [21:0] FADE_B = 22'sd10 <<< FRAC_BITS;

  logic en;
  logic [10:1] v_q;
  logic        ov_q;
  logic [OUT_W-1:0] od_q;

  frac_t [2:0]                  t1_q, t2_q;
  hash_t [7:0]                  h1_q;
  logic signed [GRAD_W-1:0]     g2_q [8];
  logic signed [GRAD_W-1:0]     g3_q [8];
  logic signed [GRAD_W-1:0]     g4_q [8];
  logic signed [38:0]           pa2_q [3];
  logic [31:0]                  pt2_q [3];
  logic signed [21:0]           bb3_q [3];
  logic [31:0]                  pc3_q [3];
  logic signed [38:0]           pf4_q [3];
  logic signed [LERP_W-1:0]     a5_q [4];
  logic signed [PROD_W-1:0]     p5_q [4];
  logic signed [FADE_W-1:0]     fv5_q, fw5_q, fv6_q, fw6_q, fw7_q, fw8_q;
  logic signed [LERP_W-1:0]     l6_q [4];
  logic signed [LERP_W-1:0]     a7_q [2];
  logic signed [PROD_W-1:0]     p7_q [2];
  logic signed [LERP_W-1:0]     l8_q [2];
  logic signed [LERP_W-1:0]     a9_q;
  logic signed [PROD_W-1:0]     p9_q;
  logic signed [SUM_W-1:0]      r10_q;

  logic signed [GRAD_W-1:0]     g1 [8];
  logic signed [21:0]           fa [3];
  logic signed [38:0]           pa1 [3];
  logic [31:0]                  pt1 [3];
  logic signed [21:0]           bb2 [3];
  logic [31:0]                  pc2 [3];
  logic signed [38:0]           pf3 [3];
  logic signed [FADE_W-1:0]     f4 [3];
  logic signed [PROD_W-1:0]     p4 [4];
  logic signed [LERP_W-1:0]     l5 [4];
  logic signed [PROD_W-1:0]     p6 [2];
  logic signed [LERP_W-1:0]     l7 [2];
  logic signed [PROD_W-1:0]     p8;
  logic signed [LERP_W-1:0]     n9;
  logic signed [SUM_W-1:0]      r9;
  logic signed [SUM_W-1:0]      c10;

  assign en          = !ov_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      g1[i] = grad(h1_q[i],
                   {(i & 1) != 0 ? 2'b11 : 2'b00, t1_q[0]},
                   {(i & 2) != 0 ? 2'b11 : 2'b00, t1_q[1]},
                   {(i & 4) != 0 ? 2'b11 : 2'b00, t1_q[2]});
    end
    for (int k = 0; k < 3; k++) begin
      fa[k]  = $signed({6'd0, t1_q[k]}) * 22'sd6 - FADE_A;
      pa1[k] = 39'($signed({1'b0, t1_q[k]})) * 39'(fa[k]);
      pt1[k] = 32'(t1_q[k]) * 32'(t1_q[k]);
      bb2[k] = 22'(pa2_q[k] >>> FRAC_BITS) + FADE_B;
      pc2[k] = 32'(pt2_q[k][31:FRAC_BITS]) * 32'(t2_q[k]);
      pf3[k] = 39'($signed({1'b0, pc3_q[k][31:FRAC_BITS]})) * 39'(bb3_q[k]);
      f4[k]  = FADE_W'(pf4_q[k] >>> FRAC_BITS);
    end
    for (int j = 0; j < 4; j++) begin
      p4[j] = PROD_W'(f4[0]) * PROD_W'(LERP_W'(g4_q[2*j+1]) - LERP_W'(g4_q[2*j]));
      l5[j] = a5_q[j] + LERP_W'(p5_q[j] >>> FRAC_BITS);
    end
    for (int j = 0; j < 2; j++) begin
      p6[j] = PROD_W'(fv6_q) * PROD_W'(l6_q[2*j+1] - l6_q[2*j]);
      l7[j] = a7_q[j] + LERP_W'(p7_q[j] >>> FRAC_BITS);
    end
    p8  = PROD_W'(fw8_q) * PROD_W'(l8_q[1] - l8_q[0]);
    n9  = a9_q + LERP_W'(p9_q >>> FRAC_BITS);
    r9  = SUM_W'(n9) + SUM_W'(cfg_i.offset);
    c10 = r10_q;
    if (c10 < SUM_W'(cfg_i.low)) c10 = SUM_W'(cfg_i.low);
    if (c10 > SUM_W'(cfg_i.high)) c10 = SUM_W'(cfg_i.high);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      ov_q <= 1'b0;
    end else if (en) begin
      v_q  <= {v_q[9:1], in_valid_i};
      ov_q <= v_q[10];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q  <= in_item_i.frac;
      h1_q  <= in_item_i.hash;
      t2_q  <= t1_q;
      g2_q  <= g1;
      pa2_q <= pa1;
      pt2_q <= pt1;
      g3_q  <= g2_q;
      bb3_q <= bb2;
      pc3_q <= pc2;
      g4_q  <= g3_q;
      pf4_q <= pf3;
      for (int j = 0; j < 4; j++) begin
        a5_q[j] <= LERP_W'(g4_q[2*j]);
      end
      p5_q  <= p4;
      fv5_q <= f4[1];
      fw5_q <= f4[2];
      l6_q  <= l5;
      fv6_q <= fv5_q;
      fw6_q <= fw5_q;
      a7_q[0] <= l6_q[0];
      a7_q[1] <= l6_q[2];
      p7_q  <= p6;
      fw7_q <= fw6_q;
      l8_q  <= l7;
      fw8_q <= fw7_q;
      a9_q  <= l8_q[0];
      p9_q  <= p8;
      r10_q <= r9;
      od_q  <= c10[OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

### hdl/perlin_noise_3d.sv
// ----------------------------------------------------------------------------
// Perlin noise 3D
// Improved 3D Perlin noise on a stream of points, with a loadable table.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_axis    in         s_tvalid/s_tready  tdata: index, value, x, y, z; tuser: mode
//  m_axis    out        m_tvalid/m_tready  tdata: noise_value
//  cfg       in         cfg_we_i           cfg_idx_i, cfg_data_i
//
//  One item is taken per cycle while no stall holds the input.
//  The front passes through three chained table lookup stages.
//  The queue holds each item in its buffer, and the back passes through fade, blend
//  and clamp stages.
//  The table is not cleared at reset; entries are valid once loaded.
//  A full queue stalls the front; an untaken result stalls the back.
`default_nettype none

module perlin_noise_3d
  import pn3d_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_tvalid_i,
  output logic                       s_tready_o,
  // table_index[7:0], table_value[15:8], x_coord[47:16], y_coord[79:48], z_coord[111:80]
  input  wire logic [IN_DATA_W-1:0]  s_tdata_i,
  // mode[0]
  input  wire logic                  s_tuser_i,
  output logic                       m_tvalid_o,
  input  wire logic                  m_tready_i,
  // noise_value[19:0], zero[23:20]
  output logic [OUT_DATA_W-1:0]      m_tdata_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i
);

  cfg_t                 cfg_q;
  logic                 fq_valid, fq_ready, qb_valid, qb_ready;
  item_t                fq_item, qb_item;
  logic [Q_CNT_W-1:0]   q_count;
  logic [OUT_W-1:0]     noise;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset <= 20'sd32768;
      cfg_q.low    <= 20'sd0;
      cfg_q.high   <= 20'sd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OFFSET:     cfg_q.offset <= cfg_data_i;
        CFG_CLAMP_LOW:  cfg_q.low    <= cfg_data_i;
        CFG_CLAMP_HIGH: cfg_q.high   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pn3d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .in_mode_i   (s_tuser_i),
    .in_index_i  (s_tdata_i[7:0]),
    .in_value_i  (s_tdata_i[15:8]),
    .in_x_i      (s_tdata_i[47:16]),
    .in_y_i      (s_tdata_i[79:48]),
    .in_z_i      (s_tdata_i[111:80]),
    .out_valid_o (fq_valid),
    .out_ready_i (fq_ready),
    .out_item_o  (fq_item)
  );

  pn3d_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fq_valid),
    .in_ready_o  (fq_ready),
    .in_item_i   (fq_item),
    .out_valid_o (qb_valid),
    .out_ready_i (qb_ready),
    .out_item_o  (qb_item),
    .count_o     (q_count)
  );

  pn3d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (qb_valid),
    .in_ready_o  (qb_ready),
    .in_item_i   (qb_item),
    .cfg_i       (cfg_q),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .out_data_o  (noise)
  );

  assign m_tdata_o = {{(OUT_DATA_W-OUT_W){1'b0}}, noise};

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count above depth");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> (fq_valid && !fq_ready))
    else $error("input stalled without a full queue");

  a_pop_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qb_valid && qb_ready) |-> (!m_tvalid_o || m_tready_i))
    else $error("queue popped while result held");

endmodule

`default_nettype wire
